// File: src/ssh_pkg.sv
// Shared types, widths and command codes for the swept-sphere nearest-hit block.
// Used by ssh_ctrl, ssh_dp and segment_sphere_earliest_hit; depends on nothing.
package ssh_pkg;

    localparam int CW  = 32;          // coordinate width, Q23.8
    localparam int TF  = 16;          // time fraction bits
    localparam int TW  = TF + 1;      // time width, Q0.16 including 1.0
    localparam int RW  = 24;          // radius width
    localparam int KW  = 64;          // key width
    localparam int MW  = CW + 3;      // multiplier operand width (signed)
    localparam int PW  = 2 * MW;      // multiplier product width
    localparam int AW  = 2 * CW + 4;  // dot product magnitude width
    localparam int HW  = AW / 2;      // half of a dot product for partial products
    localparam int R2W = 2 * (RW + 1);
    localparam int DW  = 2 * AW + 2;  // discriminant accumulator width
    localparam int AKW = AW + TW + 1; // A*k accumulator width
    localparam int SW  = AW + 2 * TF + 8; // root search quadratic width
    localparam int JW  = 5;           // bit index of the root search
    localparam int OPW = 5;

    // Multiplier operation codes.
    localparam logic [OPW-1:0] OP_DD0 = 5'd0;
    localparam logic [OPW-1:0] OP_DD1 = 5'd1;
    localparam logic [OPW-1:0] OP_DD2 = 5'd2;
    localparam logic [OPW-1:0] OP_PP0 = 5'd3;
    localparam logic [OPW-1:0] OP_PP1 = 5'd4;
    localparam logic [OPW-1:0] OP_PP2 = 5'd5;
    localparam logic [OPW-1:0] OP_PD0 = 5'd6;
    localparam logic [OPW-1:0] OP_PD1 = 5'd7;
    localparam logic [OPW-1:0] OP_PD2 = 5'd8;
    localparam logic [OPW-1:0] OP_RR  = 5'd9;
    localparam logic [OPW-1:0] OP_BLL = 5'd10;
    localparam logic [OPW-1:0] OP_BLH = 5'd11;
    localparam logic [OPW-1:0] OP_BHL = 5'd12;
    localparam logic [OPW-1:0] OP_BHH = 5'd13;
    localparam logic [OPW-1:0] OP_ALL = 5'd14;
    localparam logic [OPW-1:0] OP_ALH = 5'd15;
    localparam logic [OPW-1:0] OP_AHL = 5'd16;
    localparam logic [OPW-1:0] OP_AHH = 5'd17;
    localparam logic [OPW-1:0] OP_LX  = 5'd18;
    localparam logic [OPW-1:0] OP_LY  = 5'd19;
    localparam logic [OPW-1:0] OP_LZ  = 5'd20;

    localparam logic ACT_BEGIN = 1'b0;

    typedef struct packed {
        logic                 action;
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic signed [CW-1:0] end_z;
        logic [RW-1:0]        radius;
        logic                 eligible;
        logic [KW-1:0]        target_key;
        logic                 is_last;
    } in_word_t;

    typedef struct packed {
        logic                 hit;
        logic [KW-1:0]        hit_key;
        logic [TW-1:0]        hit_time;
        logic signed [CW-1:0] hit_x;
        logic signed [CW-1:0] hit_y;
        logic signed [CW-1:0] hit_z;
    } out_word_t;

    typedef struct packed {
        logic           capture;
        logic           load_seg;
        logic           clr_acc;
        logic           mul_en;
        logic [OPW-1:0] mul_op;
        logic           prep;
        logic           solve_init;
        logic           solve_step;
        logic [JW-1:0]  solve_j;
        logic           upd_en;
        logic           upd_zero;
        logic           emit;
    } cmd_t;

    typedef struct packed {
        logic action;
        logic eligible;
        logic is_last;
        logic comb_zero;
        logic in_sphere;
        logic a_zero;
        logic b_pos;
        logic disc_neg;
        logic past_end;
        logic out_free;
    } stat_t;

endpackage

// File: src/ssh_dp.sv
// Datapath: item and segment registers, shared multiplier, dot product and
// discriminant accumulators, shift-add root search, best-hit tracking, output word.
// Depends on ssh_pkg.
module ssh_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ssh_pkg::in_word_t        in_word,
    input  logic                     cfg_we,
    input  logic [15:0]              cfg_wdata,
    input  logic                     out_ready,
    input  ssh_pkg::cmd_t            cmd,
    output ssh_pkg::stat_t           stat,
    output logic                     out_valid,
    output ssh_pkg::out_word_t       out_word
);

    ssh_pkg::in_word_t item_reg;

    logic signed [ssh_pkg::CW-1:0] sx_reg, sy_reg, sz_reg, ex_reg, ey_reg, ez_reg;
    logic [ssh_pkg::RW-1:0]        prad_reg;
    logic [15:0]                   tol_reg;

    logic                    best_valid_reg;
    logic [ssh_pkg::TW-1:0]  best_time_reg;
    logic [ssh_pkg::KW-1:0]  best_key_reg;

    logic [ssh_pkg::CW:0] d0, d1, d2, p0, p1, p2;
    logic [ssh_pkg::RW:0] comb;

    logic signed [ssh_pkg::MW-1:0] mul_a, mul_b;
    logic signed [ssh_pkg::PW-1:0] prod_full, prod_reg;
    logic [ssh_pkg::OPW-1:0]       prod_op_reg;
    logic                          prod_vld_reg;

    logic [ssh_pkg::AW-1:0]        a_acc_reg, pp_acc_reg, c_reg, b_reg;
    logic signed [ssh_pkg::AW:0]   pd_acc_reg;
    logic [ssh_pkg::AW:0]          neg_pd;
    logic [ssh_pkg::R2W-1:0]       r2_reg;
    logic signed [ssh_pkg::DW-1:0] disc_reg;
    logic [ssh_pkg::DW-1:0]        part_ext;
    logic signed [ssh_pkg::CW-1:0] hx_reg, hy_reg, hz_reg;
    logic [ssh_pkg::CW-1:0]        lerp_off;

    logic [ssh_pkg::AKW-1:0]       ak_reg, aj_reg, b16_reg, ak_t;
    logic [ssh_pkg::SW-1:0]        a2j_reg, bj_reg, uj_reg, uj_n;
    logic signed [ssh_pkg::SW-1:0] f_reg, f_t;
    logic [ssh_pkg::TW-1:0]        k_reg;
    logic                          step_ok;

    logic signed [ssh_pkg::AW+2:0] f1;
    logic [ssh_pkg::TW-1:0]        t_new, t_diff;
    logic [ssh_pkg::TW:0]          t_sum;
    logic                          win;
    logic                          out_valid_reg;
    ssh_pkg::out_word_t            out_word_reg;

    assign d0 = {ex_reg[ssh_pkg::CW-1], ex_reg} - {sx_reg[ssh_pkg::CW-1], sx_reg};
    assign d1 = {ey_reg[ssh_pkg::CW-1], ey_reg} - {sy_reg[ssh_pkg::CW-1], sy_reg};
    assign d2 = {ez_reg[ssh_pkg::CW-1], ez_reg} - {sz_reg[ssh_pkg::CW-1], sz_reg};
    assign p0 = {sx_reg[ssh_pkg::CW-1], sx_reg}
              - {item_reg.point_x[ssh_pkg::CW-1], item_reg.point_x};
    assign p1 = {sy_reg[ssh_pkg::CW-1], sy_reg}
              - {item_reg.point_y[ssh_pkg::CW-1], item_reg.point_y};
    assign p2 = {sz_reg[ssh_pkg::CW-1], sz_reg}
              - {item_reg.point_z[ssh_pkg::CW-1], item_reg.point_z};
    assign comb = {1'b0, prad_reg} + {1'b0, item_reg.radius};

    // Operand selection for the one shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            ssh_pkg::OP_DD0: begin mul_a = {{2{d0[ssh_pkg::CW]}}, d0}; mul_b = mul_a; end
            ssh_pkg::OP_DD1: begin mul_a = {{2{d1[ssh_pkg::CW]}}, d1}; mul_b = mul_a; end
            ssh_pkg::OP_DD2: begin mul_a = {{2{d2[ssh_pkg::CW]}}, d2}; mul_b = mul_a; end
            ssh_pkg::OP_PP0: begin mul_a = {{2{p0[ssh_pkg::CW]}}, p0}; mul_b = mul_a; end
            ssh_pkg::OP_PP1: begin mul_a = {{2{p1[ssh_pkg::CW]}}, p1}; mul_b = mul_a; end
            ssh_pkg::OP_PP2: begin mul_a = {{2{p2[ssh_pkg::CW]}}, p2}; mul_b = mul_a; end
            ssh_pkg::OP_PD0:
            begin
                mul_a = {{2{p0[ssh_pkg::CW]}}, p0};
                mul_b = {{2{d0[ssh_pkg::CW]}}, d0};
            end
            ssh_pkg::OP_PD1:
            begin
                mul_a = {{2{p1[ssh_pkg::CW]}}, p1};
                mul_b = {{2{d1[ssh_pkg::CW]}}, d1};
            end
            ssh_pkg::OP_PD2:
            begin
                mul_a = {{2{p2[ssh_pkg::CW]}}, p2};
                mul_b = {{2{d2[ssh_pkg::CW]}}, d2};
            end
            ssh_pkg::OP_RR:
            begin
                mul_a = ssh_pkg::MW'(comb);
                mul_b = ssh_pkg::MW'(comb);
            end
            ssh_pkg::OP_BLL:
            begin
                mul_a = ssh_pkg::MW'(b_reg[ssh_pkg::HW-1:0]);
                mul_b = ssh_pkg::MW'(b_reg[ssh_pkg::HW-1:0]);
            end
            ssh_pkg::OP_BLH:
            begin
                mul_a = ssh_pkg::MW'(b_reg[ssh_pkg::HW-1:0]);
                mul_b = ssh_pkg::MW'(b_reg[ssh_pkg::AW-1:ssh_pkg::HW]);
            end
            ssh_pkg::OP_BHL:
            begin
                mul_a = ssh_pkg::MW'(b_reg[ssh_pkg::AW-1:ssh_pkg::HW]);
                mul_b = ssh_pkg::MW'(b_reg[ssh_pkg::HW-1:0]);
            end
            ssh_pkg::OP_BHH:
            begin
                mul_a = ssh_pkg::MW'(b_reg[ssh_pkg::AW-1:ssh_pkg::HW]);
                mul_b = ssh_pkg::MW'(b_reg[ssh_pkg::AW-1:ssh_pkg::HW]);
            end
            ssh_pkg::OP_ALL:
            begin
                mul_a = ssh_pkg::MW'(a_acc_reg[ssh_pkg::HW-1:0]);
                mul_b = ssh_pkg::MW'(c_reg[ssh_pkg::HW-1:0]);
            end
            ssh_pkg::OP_ALH:
            begin
                mul_a = ssh_pkg::MW'(a_acc_reg[ssh_pkg::HW-1:0]);
                mul_b = ssh_pkg::MW'(c_reg[ssh_pkg::AW-1:ssh_pkg::HW]);
            end
            ssh_pkg::OP_AHL:
            begin
                mul_a = ssh_pkg::MW'(a_acc_reg[ssh_pkg::AW-1:ssh_pkg::HW]);
                mul_b = ssh_pkg::MW'(c_reg[ssh_pkg::HW-1:0]);
            end
            ssh_pkg::OP_AHH:
            begin
                mul_a = ssh_pkg::MW'(a_acc_reg[ssh_pkg::AW-1:ssh_pkg::HW]);
                mul_b = ssh_pkg::MW'(c_reg[ssh_pkg::AW-1:ssh_pkg::HW]);
            end
            ssh_pkg::OP_LX:
            begin
                mul_a = {{2{d0[ssh_pkg::CW]}}, d0};
                mul_b = ssh_pkg::MW'(best_time_reg);
            end
            ssh_pkg::OP_LY:
            begin
                mul_a = {{2{d1[ssh_pkg::CW]}}, d1};
                mul_b = ssh_pkg::MW'(best_time_reg);
            end
            ssh_pkg::OP_LZ:
            begin
                mul_a = {{2{d2[ssh_pkg::CW]}}, d2};
                mul_b = ssh_pkg::MW'(best_time_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // Partial products of the discriminant are unsigned; place them by weight.
    always_comb
    begin
        part_ext = ssh_pkg::DW'(prod_reg[2*ssh_pkg::HW-1:0]);
        case (prod_op_reg)
            ssh_pkg::OP_BLH, ssh_pkg::OP_BHL, ssh_pkg::OP_ALH, ssh_pkg::OP_AHL:
                part_ext = part_ext << ssh_pkg::HW;
            ssh_pkg::OP_BHH, ssh_pkg::OP_AHH:
                part_ext = part_ext << (2 * ssh_pkg::HW);
            default:
                part_ext = part_ext;
        endcase
    end

    // Floor of d*t/2^TF, taken modulo the coordinate width.
    assign lerp_off = prod_reg[ssh_pkg::TF+ssh_pkg::CW-1:ssh_pkg::TF];
    assign neg_pd   = ~pd_acc_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_word;
        end
        prod_reg    <= prod_full;
        prod_op_reg <= cmd.mul_op;
        if (cmd.clr_acc)
        begin
            a_acc_reg  <= '0;
            pp_acc_reg <= '0;
            pd_acc_reg <= '0;
            disc_reg   <= '0;
        end
        else if (prod_vld_reg)
        begin
            case (prod_op_reg)
                ssh_pkg::OP_DD0, ssh_pkg::OP_DD1, ssh_pkg::OP_DD2:
                    a_acc_reg <= a_acc_reg + prod_reg[ssh_pkg::AW-1:0];
                ssh_pkg::OP_PP0, ssh_pkg::OP_PP1, ssh_pkg::OP_PP2:
                    pp_acc_reg <= pp_acc_reg + prod_reg[ssh_pkg::AW-1:0];
                ssh_pkg::OP_PD0, ssh_pkg::OP_PD1, ssh_pkg::OP_PD2:
                    pd_acc_reg <= pd_acc_reg + prod_reg[ssh_pkg::AW:0];
                ssh_pkg::OP_RR:
                    r2_reg <= prod_reg[ssh_pkg::R2W-1:0];
                ssh_pkg::OP_BLL, ssh_pkg::OP_BLH, ssh_pkg::OP_BHL, ssh_pkg::OP_BHH:
                    disc_reg <= disc_reg + part_ext;
                ssh_pkg::OP_ALL, ssh_pkg::OP_ALH, ssh_pkg::OP_AHL, ssh_pkg::OP_AHH:
                    disc_reg <= disc_reg - part_ext;
                ssh_pkg::OP_LX:
                    hx_reg <= sx_reg + lerp_off;
                ssh_pkg::OP_LY:
                    hy_reg <= sy_reg + lerp_off;
                ssh_pkg::OP_LZ:
                    hz_reg <= sz_reg + lerp_off;
                default:
                    hx_reg <= hx_reg;
            endcase
        end
        if (cmd.prep)
        begin
            c_reg <= pp_acc_reg - ssh_pkg::AW'(r2_reg);
            b_reg <= neg_pd[ssh_pkg::AW-1:0];
        end
    end

    // Root search: greedy over the bits of k, keeping f(k) = A k^2 - 2B 2^TF k + C 2^2TF
    // and its increments as shifted running terms, so each step is adds only.
    assign ak_t    = ak_reg + aj_reg;
    assign f_t     = f_reg + $signed(uj_reg) + $signed(a2j_reg) - $signed(bj_reg);
    assign step_ok = (ak_t <= b16_reg) && !f_t[ssh_pkg::SW-1] && !k_reg[ssh_pkg::TW-1];
    assign uj_n    = step_ok ? uj_reg + (a2j_reg << 1) : uj_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.solve_init)
        begin
            ak_reg  <= '0;
            aj_reg  <= ssh_pkg::AKW'(a_acc_reg) << ssh_pkg::TF;
            b16_reg <= ssh_pkg::AKW'(b_reg) << ssh_pkg::TF;
            a2j_reg <= ssh_pkg::SW'(a_acc_reg) << (2 * ssh_pkg::TF);
            bj_reg  <= ssh_pkg::SW'(b_reg) << (2 * ssh_pkg::TF + 1);
            uj_reg  <= '0;
            f_reg   <= $signed(ssh_pkg::SW'(c_reg) << (2 * ssh_pkg::TF));
            k_reg   <= '0;
        end
        else if (cmd.solve_step)
        begin
            if (step_ok)
            begin
                ak_reg <= ak_t;
                f_reg  <= f_t;
                k_reg  <= k_reg | (ssh_pkg::TW'(1) << cmd.solve_j);
            end
            aj_reg  <= aj_reg >> 1;
            a2j_reg <= a2j_reg >> 2;
            bj_reg  <= bj_reg >> 1;
            uj_reg  <= uj_n >> 1;
        end
    end

    // Past the segment end: vertex beyond t = 1 and f(1) > 0.
    assign f1 = $signed({3'b000, a_acc_reg}) + $signed({3'b000, c_reg})
              - $signed({2'b00, b_reg, 1'b0});

    assign t_new  = cmd.upd_zero ? '0 : k_reg;
    assign t_diff = (t_new > best_time_reg) ? t_new - best_time_reg : best_time_reg - t_new;
    assign t_sum  = {1'b0, t_new} + ssh_pkg::TW'(tol_reg);
    assign win    = !best_valid_reg
                 || (t_sum < {1'b0, best_time_reg})
                 || ((t_diff <= ssh_pkg::TW'(tol_reg)) && (item_reg.target_key < best_key_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg         <= '0;
            sy_reg         <= '0;
            sz_reg         <= '0;
            ex_reg         <= '0;
            ey_reg         <= '0;
            ez_reg         <= '0;
            prad_reg       <= '0;
            tol_reg        <= '0;
            best_valid_reg <= 1'b0;
            best_time_reg  <= '0;
            best_key_reg   <= '0;
            prod_vld_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= cmd.mul_en;
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
            if (cmd.load_seg)
            begin
                sx_reg   <= item_reg.point_x;
                sy_reg   <= item_reg.point_y;
                sz_reg   <= item_reg.point_z;
                ex_reg   <= item_reg.end_x;
                ey_reg   <= item_reg.end_y;
                ez_reg   <= item_reg.end_z;
                prad_reg <= item_reg.radius;
            end
            if (cmd.load_seg || cmd.emit)
            begin
                best_valid_reg <= 1'b0;
                best_time_reg  <= '0;
                best_key_reg   <= '0;
            end
            else if (cmd.upd_en && win)
            begin
                best_valid_reg <= 1'b1;
                best_time_reg  <= t_new;
                best_key_reg   <= item_reg.target_key;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_word_reg.hit      <= best_valid_reg;
            out_word_reg.hit_key  <= best_valid_reg ? best_key_reg : '0;
            out_word_reg.hit_time <= best_valid_reg ? best_time_reg : '0;
            out_word_reg.hit_x    <= best_valid_reg ? hx_reg : '0;
            out_word_reg.hit_y    <= best_valid_reg ? hy_reg : '0;
            out_word_reg.hit_z    <= best_valid_reg ? hz_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign stat.action    = item_reg.action;
    assign stat.eligible  = item_reg.eligible;
    assign stat.is_last   = item_reg.is_last;
    assign stat.comb_zero = (comb == '0);
    assign stat.in_sphere = (pp_acc_reg <= ssh_pkg::AW'(r2_reg));
    assign stat.a_zero    = (a_acc_reg == '0);
    assign stat.b_pos     = pd_acc_reg[ssh_pkg::AW];
    assign stat.disc_neg  = disc_reg[ssh_pkg::DW-1];
    assign stat.past_end  = (b_reg > a_acc_reg) && !f1[ssh_pkg::AW+2] && (f1 != '0);
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule

// File: src/ssh_ctrl.sv
// Sequencer for the swept-sphere nearest-hit block: steps the datapath through
// dot products, checks, discriminant, root search, best update and hit point.
// Depends on ssh_pkg.
module ssh_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ssh_pkg::stat_t stat,
    output ssh_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_MUL, S_MWAIT, S_PREP, S_CHECK, S_DISC, S_DWAIT,
        S_CHK2, S_SINIT, S_SOLVE, S_UPD, S_UPDZ, S_FIN, S_LERP, S_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [ssh_pkg::OPW-1:0] op_reg, op_next;
    logic [ssh_pkg::JW-1:0]  j_reg, j_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        j_next     = j_reg;
        cmd        = '0;
        cmd.mul_op  = op_reg;
        cmd.solve_j = j_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.action == ssh_pkg::ACT_BEGIN)
                begin
                    cmd.load_seg = 1'b1;
                    op_next      = ssh_pkg::OP_LX;
                    state_next   = stat.is_last ? S_LERP : S_IDLE;
                end
                else if (stat.eligible)
                begin
                    cmd.clr_acc = 1'b1;
                    op_next     = ssh_pkg::OP_DD0;
                    state_next  = S_MUL;
                end
                else
                begin
                    op_next    = ssh_pkg::OP_LX;
                    state_next = stat.is_last ? S_LERP : S_IDLE;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                op_next    = op_reg + 1'b1;
                if (op_reg == ssh_pkg::OP_RR)
                begin
                    state_next = S_MWAIT;
                end
            end
            S_MWAIT:
            begin
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                op_next = ssh_pkg::OP_BLL;
                if (stat.comb_zero)
                begin
                    state_next = S_FIN;
                end
                else if (stat.in_sphere)
                begin
                    state_next = S_UPDZ;
                end
                else if (stat.a_zero || !stat.b_pos)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DISC;
                end
            end
            S_DISC:
            begin
                cmd.mul_en = 1'b1;
                op_next    = op_reg + 1'b1;
                if (op_reg == ssh_pkg::OP_AHH)
                begin
                    state_next = S_DWAIT;
                end
            end
            S_DWAIT:
            begin
                state_next = S_CHK2;
            end
            S_CHK2:
            begin
                state_next = (stat.disc_neg || stat.past_end) ? S_FIN : S_SINIT;
            end
            S_SINIT:
            begin
                cmd.solve_init = 1'b1;
                j_next         = ssh_pkg::JW'(ssh_pkg::TF);
                state_next     = S_SOLVE;
            end
            S_SOLVE:
            begin
                cmd.solve_step = 1'b1;
                j_next         = j_reg - 1'b1;
                if (j_reg == '0)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.upd_en = 1'b1;
                state_next = S_FIN;
            end
            S_UPDZ:
            begin
                cmd.upd_en   = 1'b1;
                cmd.upd_zero = 1'b1;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                op_next    = ssh_pkg::OP_LX;
                state_next = stat.is_last ? S_LERP : S_IDLE;
            end
            S_LERP:
            begin
                // The last product lands in the hit registers while this state exits.
                cmd.mul_en = (op_reg != ssh_pkg::OP_LZ + 1'b1);
                op_next    = op_reg + 1'b1;
                if (op_reg == ssh_pkg::OP_LZ + 1'b1)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            j_reg     <= j_next;
        end
    end

endmodule

// File: src/segment_sphere_earliest_hit.sv
// Processing: a begin word loads the segment; an eligible candidate runs up to 10 multiplies,
// 8 discriminant partial products, 17 root search steps on one shift-add unit, and checks.
// A last word then computes the hit point and loads the output register.
// Throughput: one word at a time; the next word is taken once the previous one is done,
// while an emitted result may still wait in the output register.
// Reset (rst_n, asynchronous, active low) clears segment, radius, tolerance and best hit.
module segment_sphere_earliest_hit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ssh_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output ssh_pkg::out_word_t out_word,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata
);

    ssh_pkg::cmd_t  cmd;
    ssh_pkg::stat_t stat;

    ssh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ssh_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

endmodule

// File: tb/sv/tb_segment_sphere_earliest_hit.sv
// Self-checking testbench for segment_sphere_earliest_hit: random and directed sweeps,
// an internal nearest-hit predictor, and random stalls on both handshakes.
// Depends on ssh_pkg and the segment_sphere_earliest_hit RTL.
module tb_segment_sphere_earliest_hit;

    localparam int WATCHDOG = 20000;
    localparam logic ACT_CAND = 1'b1;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    ssh_pkg::in_word_t  in_word;
    logic               out_valid;
    logic               out_ready;
    ssh_pkg::out_word_t out_word;
    logic               cfg_we;
    logic [15:0]        cfg_wdata;

    segment_sphere_earliest_hit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // Predictor state.
    logic signed [ssh_pkg::CW-1:0] seg_start [3];
    logic signed [ssh_pkg::CW-1:0] seg_end [3];
    logic [ssh_pkg::RW-1:0]        proj_radius;
    logic                          best_valid;
    logic [ssh_pkg::TW-1:0]        best_time;
    logic [ssh_pkg::KW-1:0]        best_key;
    logic [15:0]                   tolerance;

    ssh_pkg::in_word_t  pending_words[$];
    ssh_pkg::out_word_t expected_hits[$];
    int        mismatches;
    int        accepted_in;
    int        idle_cycles;
    bit        timed_out;
    int        in_gap;
    int        out_gap;
    // Acceptance is sampled at the rising edge; the driver acts on it at the falling edge.
    logic      in_ready_seen;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // True when k / 2^TF is at or before the first root (b, c, a all positive).
    function automatic bit at_or_before_root(logic [255:0] a, logic [255:0] b,
                                             logic [255:0] c, logic [255:0] k);
        logic [255:0] l;
        logic [255:0] r;
        l = a * k;
        r = b << ssh_pkg::TF;
        if (l > r)
            return 1'b0;
        l = l * k + (c << (2 * ssh_pkg::TF));
        r = (b * k) << (ssh_pkg::TF + 1);
        return l >= r;
    endfunction

    // Hit time of the stored segment against one sphere; returns 0 on no hit.
    function automatic bit sphere_hit_time(logic signed [ssh_pkg::CW-1:0] ctr [3],
                                           logic [ssh_pkg::RW-1:0] rad,
                                           output logic [ssh_pkg::TW-1:0] t);
        logic signed [ssh_pkg::CW+1:0] d [3];
        logic signed [ssh_pkg::CW+1:0] p [3];
        logic signed [255:0]  a_s, b_s, c_s;
        logic [255:0]         a, b, c, comb;
        logic [255:0]         lo, hi, mid;
        t = '0;
        comb = 256'(proj_radius) + 256'(rad);
        if (comb == 0)
            return 1'b0;
        a_s = 0;
        b_s = 0;
        c_s = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = (ssh_pkg::CW+2)'(seg_end[i]) - (ssh_pkg::CW+2)'(seg_start[i]);
            p[i] = (ssh_pkg::CW+2)'(seg_start[i]) - (ssh_pkg::CW+2)'(ctr[i]);
            a_s += 256'(d[i]) * 256'(d[i]);
            b_s += 256'(p[i]) * 256'(d[i]);
            c_s += 256'(p[i]) * 256'(p[i]);
        end
        c_s -= $signed(comb * comb);
        if (c_s <= 0)
            return 1'b1;
        if (a_s == 0)
            return 1'b0;
        if (b_s >= 0)
            return 1'b0;
        a = a_s;
        b = -b_s;
        c = c_s;
        if (b * b < a * c)
            return 1'b0;
        if (b > a && a + c > b + b)
            return 1'b0;
        lo = 0;
        hi = 256'(1) << ssh_pkg::TF;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            if (at_or_before_root(a, b, c, mid))
                lo = mid;
            else
                hi = mid - 1;
        end
        t = lo[ssh_pkg::TW-1:0];
        return 1'b1;
    endfunction

    function automatic logic signed [ssh_pkg::CW-1:0] hit_axis(int i,
                                                              logic [ssh_pkg::TW-1:0] t);
        logic signed [ssh_pkg::CW+1:0] d;
        logic signed [63:0]            prod;
        d = (ssh_pkg::CW+2)'(seg_end[i]) - (ssh_pkg::CW+2)'(seg_start[i]);
        prod = 64'(d) * $signed({1'b0, t});
        // Arithmetic shift gives the floor for both signs.
        return seg_start[i] + ssh_pkg::CW'(prod >>> ssh_pkg::TF);
    endfunction

    task automatic predict_word(ssh_pkg::in_word_t w);
        logic signed [ssh_pkg::CW-1:0] ctr [3];
        logic [ssh_pkg::TW-1:0]        t;
        logic [ssh_pkg::TW:0]          diff;
        ssh_pkg::out_word_t            res;
        if (w.action == ssh_pkg::ACT_BEGIN)
        begin
            seg_start = '{w.point_x, w.point_y, w.point_z};
            seg_end = '{w.end_x, w.end_y, w.end_z};
            proj_radius = w.radius;
            best_valid = 1'b0;
            best_time = '0;
            best_key = '0;
        end
        else if (w.eligible)
        begin
            ctr = '{w.point_x, w.point_y, w.point_z};
            if (sphere_hit_time(ctr, w.radius, t))
            begin
                diff = (t > best_time) ? t - best_time : best_time - t;
                if (!best_valid || ({1'b0, t} + tolerance) < {1'b0, best_time}
                    || (diff <= tolerance && w.target_key < best_key))
                begin
                    best_valid = 1'b1;
                    best_time = t;
                    best_key = w.target_key;
                end
            end
        end
        if (w.is_last)
        begin
            res = '0;
            if (best_valid)
            begin
                res.hit = 1'b1;
                res.hit_key = best_key;
                res.hit_time = best_time;
                res.hit_x = hit_axis(0, best_time);
                res.hit_y = hit_axis(1, best_time);
                res.hit_z = hit_axis(2, best_time);
            end
            expected_hits.push_back(res);
            best_valid = 1'b0;
            best_time = '0;
            best_key = '0;
        end
    endtask

    // Driver: inputs change on the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready_seen)
            begin
                in_valid <= 1'b0;
            end
            else if (!in_valid)
            begin
                if (in_gap > 0)
                    in_gap <= in_gap - 1;
                else if (pending_words.size() > 0)
                begin
                    in_word <= pending_words.pop_front();
                    in_valid <= 1'b1;
                    in_gap <= rand_gap();
                end
            end
            if (out_gap > 0)
            begin
                out_ready <= 1'b0;
                out_gap <= out_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    out_gap <= rand_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        in_ready_seen <= 1'b0;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                in_ready_seen <= 1'b1;
                predict_word(in_word);
                accepted_in <= accepted_in + 1;
            end
            if (out_valid && out_ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result word %p", out_word);
                end
                else if (out_word !== expected_hits[0])
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected %p actual %p", expected_hits[0], out_word);
                    void'(expected_hits.pop_front());
                end
                else
                    void'(expected_hits.pop_front());
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG && !timed_out)
        begin
            timed_out = 1'b1;
            $display("tb_segment_sphere_earliest_hit failed");
            $finish;
        end
    end

    function automatic logic signed [ssh_pkg::CW-1:0] rand_coord(int span);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom();
        else if (r == 1)
            return ($urandom_range(0, 1) == 1) ? 32'sh7fffffff : 32'sh80000000;
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic ssh_pkg::in_word_t make_begin(bit last);
        ssh_pkg::in_word_t w;
        w = '0;
        w.action = ssh_pkg::ACT_BEGIN;
        w.point_x = rand_coord(4000);
        w.point_y = rand_coord(4000);
        w.point_z = rand_coord(4000);
        w.end_x = rand_coord(4000);
        w.end_y = rand_coord(4000);
        w.end_z = rand_coord(4000);
        w.radius = ($urandom_range(0, 15) == 0) ? ssh_pkg::RW'($urandom())
                                                 : ssh_pkg::RW'($urandom_range(0, 300));
        w.eligible = ($urandom_range(0, 1) == 1);
        w.target_key = {$urandom(), $urandom()};
        w.is_last = last;
        return w;
    endfunction

    function automatic ssh_pkg::in_word_t make_candidate(bit last);
        ssh_pkg::in_word_t w;
        w = '0;
        w.action = ACT_CAND;
        w.point_x = rand_coord(4000);
        w.point_y = rand_coord(4000);
        w.point_z = rand_coord(4000);
        w.end_x = $urandom();
        w.end_y = $urandom();
        w.end_z = $urandom();
        w.radius = ($urandom_range(0, 15) == 0) ? ssh_pkg::RW'($urandom())
                                                 : ssh_pkg::RW'($urandom_range(0, 2000));
        w.eligible = ($urandom_range(0, 9) != 0);
        // Narrow keys make key ties and tie-breaks frequent.
        w.target_key = ($urandom_range(0, 3) == 0) ? {$urandom(), $urandom()}
                                                    : 64'($urandom_range(0, 7));
        w.is_last = last;
        return w;
    endfunction

    task automatic drain_and_settle();
        while (pending_words.size() > 0 || in_valid || expected_hits.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_tolerance(logic [15:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        tolerance = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        ssh_pkg::in_word_t w;
        logic [15:0]       tol_set [4];
        int                n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_gap = 0;
        out_gap = 0;
        mismatches = 0;
        accepted_in = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        in_ready_seen = 1'b0;
        seg_start = '{'0, '0, '0};
        seg_end = '{'0, '0, '0};
        proj_radius = '0;
        best_valid = 1'b0;
        best_time = '0;
        best_key = '0;
        tolerance = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: candidates before any begin run against the zero segment.
        w = make_candidate(1'b0);
        w.point_x = '0; w.point_y = '0; w.point_z = '0; w.radius = 24'd10; w.eligible = 1'b1;
        pending_words.push_back(w);
        w.radius = '0;
        w.is_last = 1'b1;
        pending_words.push_back(w);
        // Begin with last set gives a no-hit result.
        w = make_begin(1'b1);
        pending_words.push_back(w);
        // Straight segment along x, spheres ahead, behind, degenerate and tied.
        w = '0; w.action = ssh_pkg::ACT_BEGIN; w.end_x = 32'sd25600; w.radius = '0;
        pending_words.push_back(w);
        w = '0; w.action = ACT_CAND; w.eligible = 1'b1; w.point_x = 32'sd12800;
        w.radius = 24'd256; w.target_key = 64'd9;
        pending_words.push_back(w);
        w.target_key = 64'd3;
        pending_words.push_back(w);
        w.point_x = -32'sd2560; w.target_key = 64'd1;
        pending_words.push_back(w);
        w.point_x = 32'sd25600; w.point_y = 32'sd1024; w.eligible = 1'b0; w.target_key = '0;
        pending_words.push_back(w);
        w.point_x = 32'sd1000; w.point_y = '0; w.eligible = 1'b1; w.radius = 24'hffffff;
        w.target_key = '1; w.is_last = 1'b1;
        pending_words.push_back(w);
        // Fresh group without a new begin, then a degenerate segment.
        w = '0; w.action = ACT_CAND; w.eligible = 1'b1; w.point_x = 32'sd30000;
        w.radius = 24'd4000; w.is_last = 1'b1;
        pending_words.push_back(w);
        w = '0; w.action = ssh_pkg::ACT_BEGIN; w.point_x = 32'sh7fffffff;
        w.end_x = 32'sh7fffffff;
        w.point_y = 32'sh80000000; w.end_y = 32'sh80000000; w.radius = 24'hffffff;
        pending_words.push_back(w);
        w = '0; w.action = ACT_CAND; w.eligible = 1'b1; w.point_x = 32'sh80000000;
        w.point_y = 32'sh7fffffff; w.radius = 24'hffffff; w.target_key = '1;
        w.is_last = 1'b1;
        pending_words.push_back(w);
        drain_and_settle();

        tol_set = '{16'hffff, 16'd0, 16'd200, 16'd3000};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_tolerance(tol_set[ph]);
            n = 0;
            while (n < 190)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    pending_words.push_back(make_candidate($urandom_range(0, 1) == 1));
                    n++;
                end
                else
                begin
                    int cnt;
                    cnt = $urandom_range(1, 6);
                    pending_words.push_back(make_begin($urandom_range(0, 19) == 0));
                    for (int k = 0; k < cnt; k++)
                        pending_words.push_back(make_candidate(k == cnt - 1));
                    n += cnt + 1;
                end
            end
            drain_and_settle();
        end

        if (mismatches == 0 && expected_hits.size() == 0)
            $display("tb_segment_sphere_earliest_hit passed");
        else
            $display("tb_segment_sphere_earliest_hit failed");
        $finish;
    end

endmodule
